// ===== rtl/srp_pkg.sv =====
package srp_pkg;

    // default sizing of the block
    localparam int MAX_SPHERES_DEF = 256;
    localparam int COORD_BITS_DEF  = 16;

    // fractions are unsigned values over 2^FRAC_BITS
    localparam int FRAC_BITS = 16;

    // one cell per axis of space
    localparam int NUM_AXES = 3;

    // growth of the squared distance sum over the squared axis term
    localparam int SUM_GROW = 2;

    // drain count at which the verdict of the last issued entry is in the overlap flag
    localparam int DRAIN_LAST = NUM_AXES + 2;
    localparam int DRAIN_W    = $clog2(DRAIN_LAST + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_TOO_BIG = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CTR,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

endpackage

// ===== rtl/srp_req_if.sv =====
interface srp_req_if
    import srp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-2:0] radius;
    logic [FRAC_BITS-1:0]  frac_x;
    logic [FRAC_BITS-1:0]  frac_y;
    logic [FRAC_BITS-1:0]  frac_z;

    modport source (output valid, radius, frac_x, frac_y, frac_z, input ready);
    modport sink   (input valid, radius, frac_x, frac_y, frac_z, output ready);

endinterface

// ===== rtl/srp_rsp_if.sv =====
interface srp_rsp_if
    import srp_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) ();

    localparam int CNT_W = $clog2(MAX_SPHERES + 1);

    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] center_z;
    logic [CNT_W-1:0]      placed_total;

    modport source (output valid, status, center_x, center_y, center_z, placed_total,
                    input ready);
    modport sink   (input valid, status, center_x, center_y, center_z, placed_total,
                    output ready);

endinterface

// ===== rtl/srp_cell.sv =====
module srp_cell
    import srp_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [COORD_BITS-1:0]                    space,
    input  logic [FRAC_BITS-1:0]                     frac,
    input  logic [COORD_BITS-2:0]                    radius,
    input  logic                                     issue_valid,
    input  logic [$clog2(MAX_SPHERES)-1:0]           issue_addr,
    output logic                                     issue_valid_out,
    output logic [$clog2(MAX_SPHERES)-1:0]           issue_addr_out,
    input  logic [2*COORD_BITS+SUM_GROW-1:0]         sum_in,
    output logic [2*COORD_BITS+SUM_GROW-1:0]         sum_out,
    output logic                                     sum_valid,
    input  logic                                     wr_en,
    input  logic [$clog2(MAX_SPHERES)-1:0]           wr_addr,
    output logic [COORD_BITS-1:0]                    center
);

    localparam int IDX_W  = $clog2(MAX_SPHERES);
    localparam int SUM_W  = 2 * COORD_BITS + SUM_GROW;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int PROD_W = COORD_BITS + FRAC_BITS;

    logic [COORD_BITS-1:0] mem [MAX_SPHERES];

    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [COORD_BITS-1:0] center_reg;
    logic [COORD_BITS-1:0] center_next;
    logic [COORD_BITS-1:0] span;
    logic [COORD_BITS-1:0] rd_reg;
    logic [COORD_BITS-1:0] diff;
    logic [SQ_W-1:0]       sq_reg;
    logic [SQ_W-1:0]       sq_next;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [IDX_W-1:0]      addr_fwd_reg;
    logic                  fwd_valid_reg;
    logic                  rd_valid_reg;
    logic                  sq_valid_reg;
    logic                  sum_valid_reg;

    // candidate coordinate: radius plus scaled free span of the axis
    always_comb
    begin
        span        = space - {radius, 1'b0};
        prod_next   = PROD_W'(span) * PROD_W'(frac);
        center_next = {1'b0, radius} + prod_reg[PROD_W-1:FRAC_BITS];
    end

    // squared axis distance to the stored entry, added to the neighbour's partial sum
    always_comb
    begin
        diff     = (center_reg > rd_reg) ? (center_reg - rd_reg) : (rd_reg - center_reg);
        sq_next  = SQ_W'(diff) * SQ_W'(diff);
        sum_next = sum_in + SUM_W'(sq_reg);
    end

    // coordinate store of this axis
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= center_reg;
        end
        if (issue_valid)
        begin
            rd_reg <= mem[issue_addr];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        center_reg   <= center_next;
        sq_reg       <= sq_next;
        sum_reg      <= sum_next;
        addr_fwd_reg <= issue_addr;
    end

    // valid flags along the cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= issue_valid;
            rd_valid_reg  <= issue_valid;
            sq_valid_reg  <= rd_valid_reg;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    assign issue_valid_out = fwd_valid_reg;
    assign issue_addr_out  = addr_fwd_reg;
    assign sum_out         = sum_reg;
    assign sum_valid       = sum_valid_reg;
    assign center          = center_reg;

endmodule

// ===== rtl/srp_ctrl.sv =====
module srp_ctrl
    import srp_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    srp_req_if.sink                              req,
    srp_rsp_if.source                            rsp,
    input  logic [COORD_BITS-1:0]                space [NUM_AXES],
    input  logic [COORD_BITS-1:0]                center [NUM_AXES],
    output logic [FRAC_BITS-1:0]                 frac [NUM_AXES],
    output logic [COORD_BITS-2:0]                radius,
    output logic                                 issue_valid,
    output logic [$clog2(MAX_SPHERES)-1:0]       issue_addr,
    input  logic [2*COORD_BITS+SUM_GROW-1:0]     last_sum,
    input  logic                                 last_sum_valid,
    output logic                                 wr_en,
    output logic [$clog2(MAX_SPHERES)-1:0]       wr_addr
);

    localparam int IDX_W = $clog2(MAX_SPHERES);
    localparam int CNT_W = $clog2(MAX_SPHERES + 1);
    localparam int SUM_W = 2 * COORD_BITS + SUM_GROW;
    localparam int SQ_W  = 2 * COORD_BITS;

    logic [COORD_BITS-2:0] rmem [MAX_SPHERES];

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [DRAIN_W-1:0]    drain_reg, drain_next;
    logic                  overlap_reg, overlap_next;
    logic                  issue_valid_reg, issue_valid_next;
    logic [IDX_W-1:0]      issue_addr_reg, issue_addr_next;
    status_t               status_reg, status_next;
    logic [COORD_BITS-2:0] radius_reg, radius_next;
    logic [FRAC_BITS-1:0]  frac_reg [NUM_AXES];
    logic [FRAC_BITS-1:0]  frac_next [NUM_AXES];
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [COORD_BITS-1:0] out_center_reg [NUM_AXES];
    logic [COORD_BITS-1:0] out_center_next [NUM_AXES];
    logic [CNT_W-1:0]      out_total_reg, out_total_next;

    logic [COORD_BITS-2:0] rrad_reg;
    logic [COORD_BITS-1:0] rsum;
    logic [SQ_W-1:0]       lim_reg;
    logic [SQ_W-1:0]       lim_pipe_reg [NUM_AXES];
    logic                  accept;
    logic                  too_big;
    logic                  store_en;

    // radius check against every axis extent
    always_comb
    begin
        too_big = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if ({req.radius, 1'b0} > space[a])
            begin
                too_big = 1'b1;
            end
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // stored radius and contact limit, timed to meet the last cell's sum
    always_comb
    begin
        rsum = {1'b0, radius_reg} + {1'b0, rrad_reg};
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            rmem[count_reg[IDX_W-1:0]] <= radius_reg;
        end
        if (issue_valid_reg)
        begin
            rrad_reg <= rmem[issue_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg         <= SQ_W'(rsum) * SQ_W'(rsum);
        lim_pipe_reg[0] <= lim_reg;
        for (int k = 1; k < NUM_AXES; k++)
        begin
            lim_pipe_reg[k] <= lim_pipe_reg[k-1];
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        drain_next       = drain_reg;
        overlap_next     = overlap_reg;
        issue_valid_next = 1'b0;
        issue_addr_next  = issue_addr_reg;
        status_next      = status_reg;
        radius_next      = radius_reg;
        frac_next        = frac_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_center_next  = out_center_reg;
        out_total_next   = out_total_reg;
        store_en         = 1'b0;

        // any stored sphere closer than the contact distance rejects the candidate
        if (last_sum_valid && (last_sum < SUM_W'(lim_pipe_reg[NUM_AXES-1])))
        begin
            overlap_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    radius_next  = req.radius;
                    frac_next[0] = req.frac_x;
                    frac_next[1] = req.frac_y;
                    frac_next[2] = req.frac_z;
                    overlap_next = 1'b0;
                    if (count_reg >= CNT_W'(MAX_SPHERES))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if (too_big)
                    begin
                        status_next = ST_TOO_BIG;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        status_next = ST_PLACED;
                        state_next  = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_CTR;
            end
            S_CTR:
            begin
                idx_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    issue_valid_next = 1'b1;
                    issue_addr_next  = idx_reg[IDX_W-1:0];
                    idx_next         = idx_reg + 1'b1;
                end
                else
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_W'(DRAIN_LAST))
                begin
                    if (overlap_reg)
                    begin
                        status_next = ST_OVERLAP;
                    end
                    else
                    begin
                        store_en   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_total_next  = count_reg;
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        if (status_reg == ST_FULL || status_reg == ST_TOO_BIG)
                        begin
                            out_center_next[a] = '0;
                        end
                        else
                        begin
                            out_center_next[a] = center[a];
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            drain_reg       <= '0;
            overlap_reg     <= 1'b0;
            issue_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            drain_reg       <= drain_next;
            overlap_reg     <= overlap_next;
            issue_valid_reg <= issue_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        issue_addr_reg <= issue_addr_next;
        status_reg     <= status_next;
        radius_reg     <= radius_next;
        frac_reg       <= frac_next;
        out_status_reg <= out_status_next;
        out_center_reg <= out_center_next;
        out_total_reg  <= out_total_next;
    end

    assign frac         = frac_reg;
    assign radius       = radius_reg;
    assign issue_valid  = issue_valid_reg;
    assign issue_addr   = issue_addr_reg;
    assign wr_en        = store_en;
    assign wr_addr      = count_reg[IDX_W-1:0];

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.center_x     = out_center_reg[0];
    assign rsp.center_y     = out_center_reg[1];
    assign rsp.center_z     = out_center_reg[2];
    assign rsp.placed_total = out_total_reg;

endmodule

// ===== rtl/sphere_rejection_placer.sv =====
// Places spheres in a box by rejection: each request brings a radius and three
// fractions, the candidate centre per axis is radius + (space - 2*radius)*frac/65536,
// and the candidate is stored only if it overlaps no sphere already stored (exact
// squared-distance test). One result per request: placed, overlap rejected, store
// full or radius too large. The stored spheres stream one per cycle through a row
// of three axis cells, each with its own coordinate memory and squaring multiplier
// passing a partial distance sum to the next; a store-full or too-large request
// skips that scan. No clearing pass is needed after reset.
module sphere_rejection_placer
    import srp_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    srp_req_if.sink               req,
    srp_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_SPHERES);
    localparam int SUM_W = 2 * COORD_BITS + SUM_GROW;

    logic [COORD_BITS-1:0] space_reg [NUM_AXES];
    logic [COORD_BITS-1:0] center [NUM_AXES];
    logic [FRAC_BITS-1:0]  frac [NUM_AXES];
    logic [COORD_BITS-2:0] radius;
    logic                  valid_link [NUM_AXES+1];
    logic [IDX_W-1:0]      addr_link [NUM_AXES+1];
    logic [SUM_W-1:0]      sum_link [NUM_AXES+1];
    logic                  sum_valid [NUM_AXES];
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;

    // space extent registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                space_reg[a] <= '1;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPACE_X: space_reg[0] <= cfg_data;
                REG_SPACE_Y: space_reg[1] <= cfg_data;
                REG_SPACE_Z: space_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sequencing, radius store and result register
    srp_ctrl #(
        .MAX_SPHERES (MAX_SPHERES),
        .COORD_BITS  (COORD_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .space          (space_reg),
        .center         (center),
        .frac           (frac),
        .radius         (radius),
        .issue_valid    (valid_link[0]),
        .issue_addr     (addr_link[0]),
        .last_sum       (sum_link[NUM_AXES]),
        .last_sum_valid (sum_valid[NUM_AXES-1]),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr)
    );

    assign sum_link[0] = '0;

    // row of axis cells, each taking the issued entry in the cycle after its neighbour does
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_cell
        srp_cell #(
            .MAX_SPHERES (MAX_SPHERES),
            .COORD_BITS  (COORD_BITS)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .space           (space_reg[a]),
            .frac            (frac[a]),
            .radius          (radius),
            .issue_valid     (valid_link[a]),
            .issue_addr      (addr_link[a]),
            .issue_valid_out (valid_link[a+1]),
            .issue_addr_out  (addr_link[a+1]),
            .sum_in          (sum_link[a]),
            .sum_out         (sum_link[a+1]),
            .sum_valid       (sum_valid[a]),
            .wr_en           (wr_en),
            .wr_addr         (wr_addr),
            .center          (center[a])
        );
    end

endmodule
